// ===== hdl/dbd_pkg.sv =====
`default_nettype none

package dbd_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned COUNT_W = 22;
	localparam int unsigned NUM_W   = 23;
	localparam int unsigned DOY_W   = 9;
	localparam int unsigned CENT_W  = 8;
	localparam int unsigned CORR_W  = 12;

	localparam logic [YEAR_W-1:0]  MAX_YEAR      = YEAR_W'(9999);
	localparam logic [MONTH_W-1:0] MONTHS        = MONTH_W'(12);
	localparam logic [MONTH_W-1:0] FEBRUARY      = MONTH_W'(2);
	localparam logic [12:0]        RECIP_100     = 13'd5243;
	localparam int unsigned        RECIP_SHIFT   = 19;
	localparam logic [6:0]         CENTURY       = 7'd100;
	localparam logic [8:0]         YEAR_DAYS     = 9'd365;

	typedef struct packed {
		logic [DAY_W-1:0]   first_day;
		logic [MONTH_W-1:0] first_month;
		logic [YEAR_W-1:0]  first_year;
		logic [DAY_W-1:0]   second_day;
		logic [MONTH_W-1:0] second_month;
		logic [YEAR_W-1:0]  second_year;
	} query_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               date_error;
	} answer_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic             ok;
	} day_num_t;

	// Days before the start of a month, counting months from March.
	function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] mm);
		logic [DOY_W-1:0] r;
		begin
			case (mm)
				4'd0:    r = 9'd0;
				4'd1:    r = 9'd31;
				4'd2:    r = 9'd61;
				4'd3:    r = 9'd92;
				4'd4:    r = 9'd122;
				4'd5:    r = 9'd153;
				4'd6:    r = 9'd184;
				4'd7:    r = 9'd214;
				4'd8:    r = 9'd245;
				4'd9:    r = 9'd275;
				4'd10:   r = 9'd306;
				4'd11:   r = 9'd337;
				default: r = 9'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] r;
		begin
			case (m)
				4'd2:                      r = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
				default:                   r = 5'd31;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/dbd_date_unit.sv =====
`default_nettype none

module dbd_date_unit
	import dbd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [DAY_W-1:0]   day,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic [YEAR_W-1:0]  year,
	output day_num_t                result
);

	logic                  early;
	logic [YEAR_W-1:0]     yy;
	logic [MONTH_W-1:0]    mm;
	logic [YEAR_W+12:0]    prod_y;
	logic [YEAR_W+12:0]    prod_yy;
	logic [DOY_W-1:0]      doy;

	logic [DAY_W-1:0]      day_s1;
	logic [MONTH_W-1:0]    month_s1;
	logic [YEAR_W-1:0]     year_s1;
	logic [YEAR_W-1:0]     yy_s1;
	logic [CENT_W-1:0]     cent_y_s1;
	logic [CENT_W-1:0]     cent_yy_s1;
	logic [DOY_W-1:0]      doy_s1;

	logic [YEAR_W-1:0]     cent_mul;
	logic                  div100;
	logic                  leap;
	logic                  ok;
	logic [NUM_W-1:0]      part;
	logic [CORR_W-1:0]     corr;

	logic [NUM_W-1:0]      part_s2;
	logic [CORR_W-1:0]     corr_s2;
	logic                  ok_s2;

	logic [NUM_W-1:0]      num_s3;
	logic                  ok_s3;

	always_comb begin
		early   = (month <= FEBRUARY);
		yy      = early ? (year - YEAR_W'(1)) : year;
		mm      = (month > FEBRUARY) ? (month - MONTH_W'(3)) : (month + MONTH_W'(9));
		prod_y  = (YEAR_W+13)'(year) * (YEAR_W+13)'(RECIP_100);
		prod_yy = (YEAR_W+13)'(yy) * (YEAR_W+13)'(RECIP_100);
		doy     = days_before(mm) + DOY_W'(day) - DOY_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			day_s1     <= day;
			month_s1   <= month;
			year_s1    <= year;
			yy_s1      <= yy;
			cent_y_s1  <= prod_y[RECIP_SHIFT +: CENT_W];
			cent_yy_s1 <= prod_yy[RECIP_SHIFT +: CENT_W];
			doy_s1     <= doy;
		end
	end

	always_comb begin
		cent_mul = YEAR_W'(cent_y_s1) * YEAR_W'(CENTURY);
		div100   = (cent_mul == year_s1);
		leap     = (year_s1[1:0] == 2'b00) && (!div100 || (cent_y_s1[1:0] == 2'b00));
		ok       = (month_s1 != '0) && (month_s1 <= MONTHS)
			&& (year_s1 != '0) && (year_s1 <= MAX_YEAR)
			&& (day_s1 != '0) && (day_s1 <= month_len(month_s1, leap));
		part     = NUM_W'(yy_s1) * NUM_W'(YEAR_DAYS) + NUM_W'(doy_s1);
		corr     = CORR_W'(yy_s1 >> 2) - CORR_W'(cent_yy_s1) + CORR_W'(cent_yy_s1 >> 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s2 <= part;
			corr_s2 <= corr;
			ok_s2   <= ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= part_s2 + NUM_W'(corr_s2);
			ok_s3  <= ok_s2;
		end
	end

	assign result.num = num_s3;
	assign result.ok  = ok_s3;

endmodule

`default_nettype wire

// ===== hdl/days_between_dates.sv =====
`default_nettype none

// Channel   Dir  Handshake                    Payload
// query     in   query_valid / query_stall    query_t  (two dates)
// answer    out  answer_valid / answer_stall  answer_t (day count, error flag)
//
// An accepted item passes registers s1, s2, s3 and s4; s4 holds the answer.
// A new item is accepted every cycle while the answer side is not stalled.
// A stall on the answer side freezes the whole pipeline while an answer is held.
// Reset clears the valid bits only; no item is in flight afterward.

module days_between_dates
	import dbd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   query_valid,
	output logic        query_stall,
	input  wire query_t query,
	output logic        answer_valid,
	input  wire logic   answer_stall,
	output answer_t     answer
);

	logic      adv;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;
	day_num_t  first_num;
	day_num_t  second_num;
	logic [NUM_W-1:0] diff;
	answer_t   result;
	answer_t   answer_s4;

	assign adv         = !valid_s4 || !answer_stall;
	assign query_stall = !adv;

	dbd_date_unit u_first (
		.clk    (clk),
		.en     (adv),
		.day    (query.first_day),
		.month  (query.first_month),
		.year   (query.first_year),
		.result (first_num)
	);

	dbd_date_unit u_second (
		.clk    (clk),
		.en     (adv),
		.day    (query.second_day),
		.month  (query.second_month),
		.year   (query.second_year),
		.result (second_num)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= query_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		diff = (second_num.num >= first_num.num) ? (second_num.num - first_num.num)
			: (first_num.num - second_num.num);
		if (first_num.ok && second_num.ok) begin
			result.day_count  = diff[NUM_W-1] ? '1 : diff[COUNT_W-1:0];
			result.date_error = 1'b0;
		end else begin
			result.day_count  = '0;
			result.date_error = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			answer_s4 <= result;
		end
	end

	assign answer_valid = valid_s4;
	assign answer       = answer_s4;

endmodule

`default_nettype wire
